### rtl/rss_pkg.sv
`timescale 1ns / 1ps

package rss_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SORT_KEY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 2'd1;

    // sort key codes
    localparam logic [1:0] KEY_ID    = 2'd0;
    localparam logic [1:0] KEY_AGE   = 2'd1;
    localparam logic [1:0] KEY_SCORE = 2'd2;

    localparam int KEY_W  = 32;
    localparam int STEP_W = 4;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic [15:0] record_tag;
        logic [31:0] student_key_id;
        logic [6:0]  age_years;
        logic [15:0] score_tenths;
        logic        last_record;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_tag;
        logic [31:0] out_id;
        logic [6:0]  out_age;
        logic [15:0] out_score;
        logic        out_last;
    } out_item_t;

    // one stored record
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] id;
        logic [6:0]  age;
        logic [15:0] score;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [1:0] {
        ADDR_I,
        ADDR_J,
        ADDR_J_NEXT,
        ADDR_EMIT
    } addr_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_LOAD,
        WR_I_FROM_M,
        WR_M_FROM_I
    } wr_sel_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_LAST_IN,
        C_PASS_DONE,
        C_SCAN_DONE,
        C_EMIT_DONE,
        C_OUT_FREE
    } cond_t;

    // one control word of the sequencer program
    typedef struct packed {
        logic      in_rdy;
        addr_sel_t addr_sel;
        wr_sel_t   wr_sel;
        logic      ld_i0;
        logic      ld_first;
        logic      ld_min;
        logic      scan;
        logic      inc_i;
        logic      ld_k0;
        logic      put;
        logic      clr_cnt;
        cond_t     cond;
        step_t     tgt_t;
        step_t     tgt_f;
    } ctl_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic last_in;
        logic pass_done;
        logic scan_done;
        logic emit_done;
        logic out_free;
    } stat_t;

    function automatic logic [KEY_W-1:0] key_of(input rec_t r, input logic [1:0] sel);
        logic [KEY_W-1:0] k;
        case (sel)
            KEY_ID:    k = r.id;
            KEY_AGE:   k = KEY_W'(r.age);
            KEY_SCORE: k = KEY_W'(r.score);
            default:   k = r.id;
        endcase
        return k;
    endfunction

endpackage

### rtl/rss_ram.sv
`timescale 1ns / 1ps

module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/rss_seq.sv
`timescale 1ns / 1ps

module rss_seq
    import rss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    localparam step_t ST_LOAD      = 4'd0;
    localparam step_t ST_INIT      = 4'd1;
    localparam step_t ST_OUTER     = 4'd2;
    localparam step_t ST_READ_I    = 4'd3;
    localparam step_t ST_SCAN      = 4'd4;
    localparam step_t ST_SWAP_A    = 4'd5;
    localparam step_t ST_SWAP_B    = 4'd6;
    localparam step_t ST_EMIT_INIT = 4'd7;
    localparam step_t ST_EMIT_CHK  = 4'd8;
    localparam step_t ST_EMIT_PUT  = 4'd9;
    localparam step_t ST_DONE      = 4'd10;

    // program rom
    function automatic ctl_t rom(input step_t s);
        ctl_t w;
        w          = '0;
        w.addr_sel = ADDR_I;
        w.wr_sel   = WR_NONE;
        w.cond     = C_ALWAYS;
        w.tgt_t    = ST_LOAD;
        w.tgt_f    = ST_LOAD;
        case (s)
            ST_LOAD:
            begin
                w.in_rdy = 1'b1;
                w.wr_sel = WR_LOAD;
                w.cond   = C_LAST_IN;
                w.tgt_t  = ST_INIT;
                w.tgt_f  = ST_LOAD;
            end
            ST_INIT:
            begin
                w.ld_i0 = 1'b1;
                w.tgt_t = ST_OUTER;
            end
            ST_OUTER:
            begin
                w.addr_sel = ADDR_I;
                w.ld_first = 1'b1;
                w.cond     = C_PASS_DONE;
                w.tgt_t    = ST_EMIT_INIT;
                w.tgt_f    = ST_READ_I;
            end
            ST_READ_I:
            begin
                w.addr_sel = ADDR_J;
                w.ld_min   = 1'b1;
                w.tgt_t    = ST_SCAN;
            end
            ST_SCAN:
            begin
                w.addr_sel = ADDR_J_NEXT;
                w.scan     = 1'b1;
                w.cond     = C_SCAN_DONE;
                w.tgt_t    = ST_SWAP_A;
                w.tgt_f    = ST_SCAN;
            end
            ST_SWAP_A:
            begin
                w.wr_sel = WR_I_FROM_M;
                w.tgt_t  = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                w.wr_sel = WR_M_FROM_I;
                w.inc_i  = 1'b1;
                w.tgt_t  = ST_OUTER;
            end
            ST_EMIT_INIT:
            begin
                w.ld_k0 = 1'b1;
                w.tgt_t = ST_EMIT_CHK;
            end
            ST_EMIT_CHK:
            begin
                w.addr_sel = ADDR_EMIT;
                w.cond     = C_EMIT_DONE;
                w.tgt_t    = ST_DONE;
                w.tgt_f    = ST_EMIT_PUT;
            end
            ST_EMIT_PUT:
            begin
                w.addr_sel = ADDR_EMIT;
                w.put      = 1'b1;
                w.cond     = C_OUT_FREE;
                w.tgt_t    = ST_EMIT_CHK;
                w.tgt_f    = ST_EMIT_PUT;
            end
            ST_DONE:
            begin
                w.clr_cnt = 1'b1;
                w.tgt_t   = ST_LOAD;
            end
            default:
            begin
                w.tgt_t = ST_LOAD;
            end
        endcase
        return w;
    endfunction

    step_t pc_reg;
    step_t pc_next;
    logic  taken;

    assign ctl = rom(pc_reg);

    always_comb
    begin
        case (ctl.cond)
            C_ALWAYS:    taken = 1'b1;
            C_LAST_IN:   taken = stat.last_in;
            C_PASS_DONE: taken = stat.pass_done;
            C_SCAN_DONE: taken = stat.scan_done;
            C_EMIT_DONE: taken = stat.emit_done;
            C_OUT_FREE:  taken = stat.out_free;
            default:     taken = 1'b1;
        endcase
        pc_next = taken ? ctl.tgt_t : ctl.tgt_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

### rtl/rss_dp.sv
`timescale 1ns / 1ps

module rss_dp
    import rss_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_t       ctl,
    input  logic [1:0] key_sel,
    input  logic       desc,
    input  logic       in_valid,
    input  in_item_t   in_item,
    input  logic       out_stall,
    output logic       out_valid,
    output out_item_t  out_item,
    output stat_t      stat
);

    localparam int ADDR_W = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] i_next;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] j_next;
    logic [CNT_W-1:0] m_reg;
    logic [CNT_W-1:0] m_next;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] k_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [KEY_W-1:0] min_key_reg;
    rec_t             rec_i_reg;
    rec_t             rec_m_reg;
    out_item_t        out_item_reg;

    logic [CNT_W-1:0]  i_plus;
    logic [CNT_W-1:0]  j_plus;
    logic [CNT_W-1:0]  k_plus;
    logic [CNT_W-1:0]  emit_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              we;
    rec_t              wr_data;
    rec_t              rd_data;
    logic [KEY_W-1:0]  cand_key;
    logic              better;
    logic              in_acc;
    logic              put_now;

    assign in_acc   = in_valid & ctl.in_rdy;
    assign i_plus   = i_reg + CNT_ONE;
    assign j_plus   = j_reg + CNT_ONE;
    assign k_plus   = k_reg + CNT_ONE;
    // descending order is the ascending store read back to front
    assign emit_idx = desc ? (cnt_reg - CNT_ONE - k_reg) : k_reg;
    assign cand_key = key_of(rd_data, key_sel);
    assign better   = cand_key < min_key_reg;

    assign stat.last_in   = in_acc & in_item.last_record;
    assign stat.pass_done = i_plus >= cnt_reg;
    assign stat.scan_done = j_plus >= cnt_reg;
    assign stat.emit_done = k_reg == cnt_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign put_now = ctl.put & stat.out_free;

    always_comb
    begin
        case (ctl.addr_sel)
            ADDR_I:      rd_addr = i_reg[ADDR_W-1:0];
            ADDR_J:      rd_addr = j_reg[ADDR_W-1:0];
            ADDR_J_NEXT: rd_addr = j_plus[ADDR_W-1:0];
            ADDR_EMIT:   rd_addr = emit_idx[ADDR_W-1:0];
            default:     rd_addr = i_reg[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        we      = 1'b0;
        wr_addr = cnt_reg[ADDR_W-1:0];
        wr_data = rec_m_reg;
        case (ctl.wr_sel)
            WR_NONE:
            begin
                we = 1'b0;
            end
            WR_LOAD:
            begin
                // records past capacity are dropped
                we      = in_acc && (cnt_reg < CNT_MAX);
                wr_addr = cnt_reg[ADDR_W-1:0];
                wr_data = '{tag:   in_item.record_tag,
                            id:    in_item.student_key_id,
                            age:   in_item.age_years,
                            score: in_item.score_tenths};
            end
            WR_I_FROM_M:
            begin
                we      = 1'b1;
                wr_addr = i_reg[ADDR_W-1:0];
                wr_data = rec_m_reg;
            end
            WR_M_FROM_I:
            begin
                we      = 1'b1;
                wr_addr = m_reg[ADDR_W-1:0];
                wr_data = rec_i_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    rss_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (we && (ctl.wr_sel == WR_LOAD))
        begin
            cnt_next = cnt_reg + CNT_ONE;
        end
        if (ctl.clr_cnt)
        begin
            cnt_next = '0;
        end
        if (ctl.ld_i0)
        begin
            i_next = '0;
        end
        if (ctl.inc_i)
        begin
            i_next = i_plus;
        end
        if (ctl.ld_first)
        begin
            m_next = i_reg;
            j_next = i_plus;
        end
        if (ctl.scan)
        begin
            j_next = j_plus;
            if (better)
            begin
                m_next = j_reg;
            end
        end
        if (ctl.ld_k0)
        begin
            k_next = '0;
        end
        if (put_now)
        begin
            k_next         = k_plus;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            m_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            m_reg         <= m_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_min)
        begin
            min_key_reg <= cand_key;
            rec_i_reg   <= rd_data;
            rec_m_reg   <= rd_data;
        end
        // first strict minimum wins
        if (ctl.scan && better)
        begin
            min_key_reg <= cand_key;
            rec_m_reg   <= rd_data;
        end
        if (put_now)
        begin
            out_item_reg <= '{out_tag:   rd_data.tag,
                              out_id:    rd_data.id,
                              out_age:   rd_data.age,
                              out_score: rd_data.score,
                              out_last:  k_plus == cnt_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("record count past capacity");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan |-> (j_reg < cnt_reg) && (j_reg > i_reg))
        else $error("scan index outside unsorted part");

    a_swap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_sel == WR_M_FROM_I) |-> (m_reg >= i_reg) && (m_reg < cnt_reg))
        else $error("minimum index outside unsorted part");

    a_put_range: assert property (@(posedge clk) disable iff (!rst_n)
        put_now |-> (k_reg < cnt_reg))
        else $error("item emitted past stored set");

    a_put_valid: assert property (@(posedge clk) disable iff (!rst_n)
        put_now |=> out_valid_reg)
        else $error("emitted item not presented");
`endif

endmodule

### rtl/record_selection_sorter_unit.sv
`timescale 1ns / 1ps

// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------
// in       | in_valid / in_stall        | in_item (in_item_t)
// out      | out_valid / out_stall      | out_item (out_item_t)
// cfg      | cfg_we                     | cfg_index, cfg_wdata
//
// loading takes one cycle per item while the sequencer sits in its load step
// after the last item of a set, the stored records are sorted in place, at a
// pace set by the single read port of the record ram: one compare per cycle
// each sorted item then leaves through the emit check and put steps, held by
// out_stall, and the done step closes the set before the next item is taken
// reset clears the record count, the sequencer and the output valid
// in_stall is high whenever the sequencer is not in its load step

module record_selection_sorter_unit
    import rss_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [1:0] key_sel_reg;
    logic       desc_reg;
    ctl_t       ctl;
    stat_t      stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_sel_reg <= KEY_ID;
            desc_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SORT_KEY:   key_sel_reg <= cfg_wdata[1:0];
                CFG_DESCENDING: desc_reg    <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    assign in_stall = !ctl.in_rdy;

    rss_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    rss_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .key_sel   (key_sel_reg),
        .desc      (desc_reg),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .stat      (stat)
    );

endmodule
